// ===== src/ctt_pkg.sv =====
// Shared types and constants for the connection tracking table.
// No dependencies.
`timescale 1ns / 1ps
package ctt_pkg;
  localparam int MaxEndpoints = 16;
  localparam int SlotBits = 4;
  localparam int AddrBits = 48;
  localparam logic [31:0] TimeoutReset = 32'd5000;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_CONNECTING = 2'd1;
  localparam logic [1:0] ST_CONNECTED = 2'd2;

  localparam logic [2:0] PKT_REQUEST = 3'd0;
  localparam logic [2:0] PKT_ESTABLISH = 3'd1;
  localparam logic [2:0] PKT_DISCONNECT = 3'd2;
  localparam logic [2:0] PKT_PAYLOAD = 3'd3;
  localparam logic [2:0] PKT_TIMESYNC = 3'd4;

  localparam logic [3:0] EV_BAD_PROTO = 4'd0;
  localparam logic [3:0] EV_FULL = 4'd1;
  localparam logic [3:0] EV_UNKNOWN = 4'd2;
  localparam logic [3:0] EV_ADDED = 4'd3;
  localparam logic [3:0] EV_CONNECTED = 4'd4;
  localparam logic [3:0] EV_IGNORED = 4'd5;
  localparam logic [3:0] EV_DISC_NOTIFY = 4'd6;
  localparam logic [3:0] EV_REMOVED = 4'd7;
  localparam logic [3:0] EV_PAYLOAD = 4'd8;
  localparam logic [3:0] EV_TIMESYNC = 4'd9;
  localparam logic [3:0] EV_RESPONSE = 4'd10;
  localparam logic [3:0] EV_DUE = 4'd11;
  localparam logic [3:0] EV_TO_NOTIFY = 4'd12;
  localparam logic [3:0] EV_TO_SILENT = 4'd13;
  localparam logic [3:0] EV_SWEEP_DONE = 4'd14;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_PROTOCOL = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LOAD, CMD_PACKET, CMD_OUT_SLOT, CMD_TO_SLOT, CMD_DONE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic [SlotBits-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic [MaxEndpoints-1:0] valid;
  } status_t;
endpackage

// ===== src/connection_tracking_table.sv =====
// Connection tracking table: 16-slot peer table with handshake and sweep.
// A packet word is loaded into the item registers and decided into the result
// register, giving one result word; the next word is accepted only once the
// controller is back in idle and the result word has been taken.
// A sweep gives a word per occupied slot, then per timed-out slot, then a done word; output stalls hold it.
// rst (synchronous) frees all slots, timeout 5000, expected protocol 0.
`timescale 1ns / 1ps
module connection_tracking_table (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic action,
  input  logic [31:0] now_ms,
  input  logic [ctt_pkg::AddrBits-1:0] src_addr,
  input  logic [31:0] protocol_id,
  input  logic [2:0] pkt_type,
  input  logic [15:0] req_salt,
  input  logic [15:0] key,
  output logic out_valid,
  input  logic out_stall,
  output logic [3:0] event_code,
  output logic [3:0] slot,
  output logic [ctt_pkg::AddrBits-1:0] peer_addr,
  output logic [15:0] salt_client,
  output logic [15:0] salt_server,
  output logic last_of_run,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data
);
  ctt_pkg::cmd_t cmd;
  ctt_pkg::status_t status;
  logic out_emit;

  assign cfg_ready = 1'b1;

  ctt_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .out_emit(out_emit),
    .status(status), .cmd(cmd)
  );

  ctt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .out_emit(out_emit),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index[0]), .cfg_data(cfg_data),
    .in_action(action), .in_now(now_ms), .in_addr(src_addr),
    .in_proto(protocol_id), .in_type(pkt_type), .in_csalt(req_salt),
    .in_key(key), .r_code(event_code), .r_slot(slot), .r_addr(peer_addr),
    .r_csalt(salt_client), .r_ssalt(salt_server), .r_last(last_of_run)
  );
endmodule

// ===== src/ctt_datapath.sv =====
// Slot table, item registers and result register of the connection table.
// Depends on ctt_pkg.
`timescale 1ns / 1ps
module ctt_datapath (
  input  logic clk,
  input  logic rst,
  input  ctt_pkg::cmd_t cmd,
  output ctt_pkg::status_t status,
  output logic out_emit,
  input  logic cfg_we,
  input  logic cfg_sel,
  input  logic [31:0] cfg_data,
  input  logic in_action,
  input  logic [31:0] in_now,
  input  logic [ctt_pkg::AddrBits-1:0] in_addr,
  input  logic [31:0] in_proto,
  input  logic [2:0] in_type,
  input  logic [15:0] in_csalt,
  input  logic [15:0] in_key,
  output logic [3:0] r_code,
  output logic [3:0] r_slot,
  output logic [ctt_pkg::AddrBits-1:0] r_addr,
  output logic [15:0] r_csalt,
  output logic [15:0] r_ssalt,
  output logic r_last
);
  localparam int N = ctt_pkg::MaxEndpoints;
  localparam int SB = ctt_pkg::SlotBits;

  logic [1:0] st [N];
  logic [ctt_pkg::AddrBits-1:0] sa [N];
  logic [15:0] sc [N];
  logic [15:0] ss [N];
  logic [31:0] sl [N];
  logic [4:0] live;
  logic [31:0] timeout, proto;

  logic action;
  logic [31:0] now, iproto;
  logic [ctt_pkg::AddrBits-1:0] addr;
  logic [2:0] ptype;
  logic [15:0] csalt, key;

  logic hit, has_free;
  logic [SB-1:0] hit_idx, free_idx;
  logic [N-1:0] valid;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      valid[i] = st[i] != ctt_pkg::ST_FREE;
      if (valid[i] && sa[i] == addr) begin
        hit = 1'b1;
        hit_idx = SB'(i);
      end
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = SB'(i);
      end
    end
  end

  assign status.is_sweep = action;
  assign status.valid = valid;

  logic [SB-1:0] ci;
  logic [31:0] age;
  assign ci = cmd.idx;
  assign age = now - sl[ci];

  always_ff @(posedge clk) begin
    out_emit <= 1'b0;
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        st[i] <= ctt_pkg::ST_FREE;
        sa[i] <= '0;
        sc[i] <= '0;
        ss[i] <= '0;
        sl[i] <= '0;
      end
      live <= '0;
      timeout <= ctt_pkg::TimeoutReset;
      proto <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == ctt_pkg::CFG_TIMEOUT) timeout <= cfg_data;
        else proto <= cfg_data;
      end
      unique case (cmd.op)
        ctt_pkg::CMD_LOAD: begin
          action <= in_action;
          now <= in_now;
          addr <= in_addr;
          iproto <= in_proto;
          ptype <= in_type;
          csalt <= in_csalt;
          key <= in_key;
        end
        ctt_pkg::CMD_PACKET: begin
          out_emit <= 1'b1;
          r_last <= 1'b1;
          r_slot <= hit_idx;
          r_addr <= sa[hit_idx];
          r_csalt <= sc[hit_idx];
          r_ssalt <= ss[hit_idx];
          if (iproto != proto || (!hit && ptype != ctt_pkg::PKT_REQUEST)
              || (!hit && (live >= 5'(N) || !has_free))) begin
            r_slot <= '0;
            r_addr <= '0;
            r_csalt <= '0;
            r_ssalt <= '0;
            if (iproto != proto) r_code <= ctt_pkg::EV_BAD_PROTO;
            else if (ptype != ctt_pkg::PKT_REQUEST) r_code <= ctt_pkg::EV_UNKNOWN;
            else r_code <= ctt_pkg::EV_FULL;
          end else if (!hit) begin
            st[free_idx] <= ctt_pkg::ST_CONNECTING;
            sa[free_idx] <= addr;
            sc[free_idx] <= csalt;
            ss[free_idx] <= now[15:0];
            sl[free_idx] <= now;
            live <= live + 5'd1;
            r_code <= ctt_pkg::EV_ADDED;
            r_slot <= free_idx;
            r_addr <= addr;
            r_csalt <= csalt;
            r_ssalt <= now[15:0];
          end else if (ptype == ctt_pkg::PKT_ESTABLISH
                       && st[hit_idx] == ctt_pkg::ST_CONNECTING) begin
            if (key == (sc[hit_idx] ^ ss[hit_idx])) begin
              st[hit_idx] <= ctt_pkg::ST_CONNECTED;
              sl[hit_idx] <= now;
              r_code <= ctt_pkg::EV_CONNECTED;
            end else r_code <= ctt_pkg::EV_IGNORED;
          end else if (ptype == ctt_pkg::PKT_DISCONNECT) begin
            r_code <= (st[hit_idx] == ctt_pkg::ST_CONNECTED) ?
                      ctt_pkg::EV_DISC_NOTIFY : ctt_pkg::EV_REMOVED;
            st[hit_idx] <= ctt_pkg::ST_FREE;
            sa[hit_idx] <= '0;
            sc[hit_idx] <= '0;
            ss[hit_idx] <= '0;
            sl[hit_idx] <= '0;
            if (live != 5'd0) live <= live - 5'd1;
          end else if (ptype == ctt_pkg::PKT_PAYLOAD
                       && st[hit_idx] == ctt_pkg::ST_CONNECTED) begin
            sl[hit_idx] <= now;
            r_code <= ctt_pkg::EV_PAYLOAD;
          end else if (ptype == ctt_pkg::PKT_TIMESYNC) begin
            r_code <= ctt_pkg::EV_TIMESYNC;
          end else r_code <= ctt_pkg::EV_IGNORED;
        end
        ctt_pkg::CMD_OUT_SLOT: begin
          out_emit <= 1'b1;
          r_last <= 1'b0;
          r_code <= (st[ci] == ctt_pkg::ST_CONNECTED) ? ctt_pkg::EV_DUE
                                                      : ctt_pkg::EV_RESPONSE;
          r_slot <= ci;
          r_addr <= sa[ci];
          r_csalt <= sc[ci];
          r_ssalt <= ss[ci];
        end
        ctt_pkg::CMD_TO_SLOT: begin
          if (age > timeout) begin
            out_emit <= 1'b1;
            r_last <= 1'b0;
            r_code <= (st[ci] == ctt_pkg::ST_CONNECTED) ? ctt_pkg::EV_TO_NOTIFY
                                                        : ctt_pkg::EV_TO_SILENT;
            r_slot <= ci;
            r_addr <= sa[ci];
            r_csalt <= sc[ci];
            r_ssalt <= ss[ci];
            st[ci] <= ctt_pkg::ST_FREE;
            sa[ci] <= '0;
            sc[ci] <= '0;
            ss[ci] <= '0;
            sl[ci] <= '0;
            if (live != 5'd0) live <= live - 5'd1;
          end
        end
        ctt_pkg::CMD_DONE: begin
          out_emit <= 1'b1;
          r_last <= 1'b1;
          r_code <= ctt_pkg::EV_SWEEP_DONE;
          r_slot <= '0;
          r_addr <= '0;
          r_csalt <= '0;
          r_ssalt <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== src/ctt_controller.sv =====
// Sequencer for packet and sweep items of the connection table.
// Depends on ctt_pkg.
`timescale 1ns / 1ps
module ctt_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  input  logic out_emit,
  input  ctt_pkg::status_t status,
  output ctt_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_OUT, S_TO, S_DONE, S_WAIT} state_t;
  localparam int SB = ctt_pkg::SlotBits;
  state_t state;
  logic [SB-1:0] idx;
  logic busy_out;
  logic hold;
  logic accept;

  assign in_stall = state != S_IDLE || busy_out;
  assign accept = in_valid && !in_stall;
  assign out_valid = busy_out;
  assign hold = busy_out || out_emit;

  always_comb begin
    cmd.op = ctt_pkg::CMD_NONE;
    cmd.idx = idx;
    unique case (state)
      S_IDLE: if (accept) cmd.op = ctt_pkg::CMD_LOAD;
      S_DECIDE: if (!status.is_sweep) cmd.op = ctt_pkg::CMD_PACKET;
      S_OUT: if (!hold && status.valid[idx]) cmd.op = ctt_pkg::CMD_OUT_SLOT;
      S_TO: if (!hold && status.valid[idx]) cmd.op = ctt_pkg::CMD_TO_SLOT;
      S_DONE: if (!hold) cmd.op = ctt_pkg::CMD_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy_out <= 1'b0;
      idx <= '0;
    end else begin
      if (out_emit) busy_out <= 1'b1;
      else if (!out_stall) busy_out <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) state <= S_DECIDE;
        S_DECIDE: begin
          idx <= '0;
          state <= status.is_sweep ? S_OUT : S_WAIT;
        end
        S_OUT, S_TO: begin
          if (!hold) begin
            if (idx == SB'(ctt_pkg::MaxEndpoints - 1)) begin
              idx <= '0;
              state <= (state == S_OUT) ? S_TO : S_DONE;
            end else idx <= idx + 1'b1;
          end
        end
        S_DONE: if (!hold) state <= S_WAIT;
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/tb_connection_tracking_table.sv =====
// Self-checking bench for connection_tracking_table: a predictor of the peer
// table checks every result word, with bursty input and random output stall.
// Depends on ctt_pkg and the connection_tracking_table RTL.
`timescale 1ns / 1ps
module tb_connection_tracking_table;
  localparam int N = ctt_pkg::MaxEndpoints;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [47:0] src_addr;
    logic [31:0] protocol_id;
    logic [2:0]  pkt_type;
    logic [15:0] req_salt;
    logic [15:0] key;
  } pkt_word_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [3:0]  slot;
    logic [47:0] peer_addr;
    logic [15:0] salt_client;
    logic [15:0] salt_server;
    logic        last_of_run;
  } event_word_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic action;
  logic [31:0] now_ms;
  logic [47:0] src_addr;
  logic [31:0] protocol_id;
  logic [2:0] pkt_type;
  logic [15:0] req_salt, key;
  logic out_valid, out_stall;
  logic [3:0] event_code, slot;
  logic [47:0] peer_addr;
  logic [15:0] salt_client, salt_server;
  logic last_of_run;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  connection_tracking_table dut (.*);

  // predictor state
  logic [1:0]  tbl_state [N];
  logic [47:0] tbl_addr [N];
  logic [15:0] tbl_csalt [N];
  logic [15:0] tbl_ssalt [N];
  logic [31:0] tbl_last [N];
  int unsigned tbl_live;
  logic [31:0] cur_timeout, cur_proto;

  pkt_word_t   pending_words[$];
  event_word_t expected_events[$];
  int errors = 0, sent = 0, seen = 0;
  longint cycles = 0;
  bit run_active = 0;
  logic in_fire;
  int gap_left = 0, burst_left = 0;

  function automatic event_word_t make_event(logic [3:0] code, int idx, logic last);
    event_word_t e;
    e = '0;
    e.event_code = code;
    e.last_of_run = last;
    if (idx >= 0) begin
      e.slot = idx[3:0];
      e.peer_addr = tbl_addr[idx];
      e.salt_client = tbl_csalt[idx];
      e.salt_server = tbl_ssalt[idx];
    end
    return e;
  endfunction

  function automatic void free_slot(int i);
    tbl_state[i] = ctt_pkg::ST_FREE;
    tbl_addr[i] = '0;
    tbl_csalt[i] = '0;
    tbl_ssalt[i] = '0;
    tbl_last[i] = '0;
    if (tbl_live > 0) tbl_live--;
  endfunction

  function automatic void predict_events(pkt_word_t w);
    int hit;
    int fr;
    logic [31:0] age;
    hit = -1;
    fr = -1;
    if (w.action) begin
      for (int i = 0; i < N; i++) begin
        if (tbl_state[i] == ctt_pkg::ST_CONNECTING)
          expected_events.push_back(make_event(ctt_pkg::EV_RESPONSE, i, 1'b0));
        else if (tbl_state[i] == ctt_pkg::ST_CONNECTED)
          expected_events.push_back(make_event(ctt_pkg::EV_DUE, i, 1'b0));
      end
      for (int i = 0; i < N; i++) begin
        if (tbl_state[i] != ctt_pkg::ST_FREE) begin
          age = w.now_ms - tbl_last[i];
          if (age > cur_timeout) begin
            expected_events.push_back(make_event(
              tbl_state[i] == ctt_pkg::ST_CONNECTED ? ctt_pkg::EV_TO_NOTIFY
                                                    : ctt_pkg::EV_TO_SILENT, i, 1'b0));
            free_slot(i);
          end
        end
      end
      expected_events.push_back(make_event(ctt_pkg::EV_SWEEP_DONE, -1, 1'b1));
      return;
    end
    if (w.protocol_id != cur_proto) begin
      expected_events.push_back(make_event(ctt_pkg::EV_BAD_PROTO, -1, 1'b1));
      return;
    end
    for (int i = N - 1; i >= 0; i--)
      if (tbl_state[i] != ctt_pkg::ST_FREE && tbl_addr[i] == w.src_addr) hit = i;
    if (hit < 0) begin
      if (w.pkt_type != ctt_pkg::PKT_REQUEST) begin
        expected_events.push_back(make_event(ctt_pkg::EV_UNKNOWN, -1, 1'b1));
        return;
      end
      for (int i = N - 1; i >= 0; i--)
        if (tbl_state[i] == ctt_pkg::ST_FREE) fr = i;
      if (tbl_live < N && fr >= 0) begin
        tbl_state[fr] = ctt_pkg::ST_CONNECTING;
        tbl_addr[fr] = w.src_addr;
        tbl_csalt[fr] = w.req_salt;
        tbl_last[fr] = w.now_ms;
        tbl_ssalt[fr] = w.now_ms[15:0];
        tbl_live++;
        expected_events.push_back(make_event(ctt_pkg::EV_ADDED, fr, 1'b1));
      end else expected_events.push_back(make_event(ctt_pkg::EV_FULL, -1, 1'b1));
      return;
    end
    if (w.pkt_type == ctt_pkg::PKT_ESTABLISH && tbl_state[hit] == ctt_pkg::ST_CONNECTING) begin
      if (w.key == (tbl_csalt[hit] ^ tbl_ssalt[hit])) begin
        tbl_state[hit] = ctt_pkg::ST_CONNECTED;
        tbl_last[hit] = w.now_ms;
        expected_events.push_back(make_event(ctt_pkg::EV_CONNECTED, hit, 1'b1));
      end else expected_events.push_back(make_event(ctt_pkg::EV_IGNORED, hit, 1'b1));
    end else if (w.pkt_type == ctt_pkg::PKT_DISCONNECT) begin
      expected_events.push_back(make_event(
        tbl_state[hit] == ctt_pkg::ST_CONNECTED ? ctt_pkg::EV_DISC_NOTIFY
                                                : ctt_pkg::EV_REMOVED, hit, 1'b1));
      free_slot(hit);
    end else if (w.pkt_type == ctt_pkg::PKT_PAYLOAD
                 && tbl_state[hit] == ctt_pkg::ST_CONNECTED) begin
      tbl_last[hit] = w.now_ms;
      expected_events.push_back(make_event(ctt_pkg::EV_PAYLOAD, hit, 1'b1));
    end else if (w.pkt_type == ctt_pkg::PKT_TIMESYNC) begin
      expected_events.push_back(make_event(ctt_pkg::EV_TIMESYNC, hit, 1'b1));
    end else expected_events.push_back(make_event(ctt_pkg::EV_IGNORED, hit, 1'b1));
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts with gaps; advance on accepted word
  always @(negedge clk) begin
    if (rst || !run_active) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_valid) begin
        void'(pending_words.pop_front());
        sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        {action, now_ms, src_addr, protocol_id, pkt_type, req_salt, key} <= pending_words[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else in_valid <= 1'b0;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else case ((cycles / 200) % 3)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      cycles++;
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        predict_events({action, now_ms, src_addr, protocol_id, pkt_type, req_salt, key});
      if (out_valid && !out_stall) begin
        event_word_t e;
        seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected result word, event_code %0d", event_code);
          errors++;
        end else begin
          e = expected_events.pop_front();
          if (event_code !== e.event_code) begin
            $error("event_code expected %0d actual %0d", e.event_code, event_code); errors++;
          end
          if (slot !== e.slot) begin
            $error("slot expected %0d actual %0d", e.slot, slot); errors++;
          end
          if (peer_addr !== e.peer_addr) begin
            $error("peer_addr expected %h actual %h", e.peer_addr, peer_addr); errors++;
          end
          if (salt_client !== e.salt_client) begin
            $error("salt_client expected %h actual %h", e.salt_client, salt_client); errors++;
          end
          if (salt_server !== e.salt_server) begin
            $error("salt_server expected %h actual %h", e.salt_server, salt_server); errors++;
          end
          if (last_of_run !== e.last_of_run) begin
            $error("last_of_run expected %0d actual %0d", e.last_of_run, last_of_run); errors++;
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [0:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ctt_pkg::CFG_TIMEOUT) cur_timeout = data;
    else cur_proto = data;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain_queue();
    while (pending_words.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pkt_word_t make_pkt(logic [31:0] t, logic [47:0] a, logic [2:0] ty,
                                         logic [15:0] cs, logic [15:0] k);
    pkt_word_t w;
    w.action = 0; w.now_ms = t; w.src_addr = a; w.protocol_id = cur_proto;
    w.pkt_type = ty; w.req_salt = cs; w.key = k;
    return w;
  endfunction

  function automatic pkt_word_t make_rand();
    pkt_word_t w;
    w.action = 1'($urandom);
    w.now_ms = $urandom;
    w.src_addr = 48'({$urandom, $urandom});
    w.protocol_id = $urandom;
    w.pkt_type = 3'($urandom);
    w.req_salt = 16'($urandom);
    w.key = 16'($urandom);
    return w;
  endfunction

  function automatic pkt_word_t make_sweep(logic [31:0] t);
    pkt_word_t w;
    w = make_rand();
    w.action = 1; w.now_ms = t;
    return w;
  endfunction

  // random phase: mixed packet types, sweeps and handshakes over a small address pool
  task automatic random_phase(int n, logic [31:0] t0, int step_max);
    logic [31:0] t;
    logic [47:0] pool [6];
    int p;
    pkt_word_t w;
    t = t0;
    for (int i = 0; i < 6; i++) pool[i] = 48'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      t += $urandom_range(0, step_max);
      p = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
        0: w = make_sweep(t);
        1: begin
          w = make_rand();
          w.action = 0;
        end
        2: w = make_pkt(t, pool[p], ctt_pkg::PKT_ESTABLISH, 16'd0, 16'($urandom));
        default: begin
          w = make_pkt(t, pool[p], 3'($urandom_range(0, 7)), 16'($urandom), 16'd0);
          // pick a matching key when the slot is known to us
          for (int s = 0; s < N; s++)
            if (tbl_state[s] != ctt_pkg::ST_FREE && tbl_addr[s] == pool[p]
                && $urandom_range(0, 1))
              begin
                w.pkt_type = ctt_pkg::PKT_ESTABLISH;
                w.key = tbl_csalt[s] ^ tbl_ssalt[s];
              end
        end
      endcase
      pending_words.push_back(w);
      while (pending_words.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0; out_stall = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    {action, now_ms, src_addr, protocol_id, pkt_type, req_salt, key} = '0;
    cur_timeout = ctt_pkg::TimeoutReset;
    cur_proto = '0;
    for (int i = 0; i < N; i++) begin
      tbl_state[i] = ctt_pkg::ST_FREE; tbl_addr[i] = '0; tbl_csalt[i] = '0;
      tbl_ssalt[i] = '0; tbl_last[i] = '0;
    end
    tbl_live = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    run_active = 1;

    // directed: every packet type, wrong and right key, full table
    pending_words.push_back(make_pkt(32'd100, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_REQUEST,
                                     16'hFFFF, 16'd0));
    pending_words.push_back(make_pkt(32'd110, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_REQUEST,
                                     16'h1, 16'd0));
    pending_words.push_back(make_pkt(32'd120, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_ESTABLISH,
                                     16'd0, 16'h1234));
    pending_words.push_back(make_pkt(32'd130, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_PAYLOAD,
                                     16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd140, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_ESTABLISH,
                                     16'd0, 16'hFFFF ^ 16'd100));
    pending_words.push_back(make_pkt(32'd150, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_ESTABLISH,
                                     16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd160, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_PAYLOAD,
                                     16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd170, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_TIMESYNC,
                                     16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd180, 48'hFFFF_FFFF_FFFF, 3'd7, 16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd190, 48'h0, ctt_pkg::PKT_TIMESYNC, 16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd200, 48'h0, ctt_pkg::PKT_REQUEST, 16'h0, 16'd0));
    pending_words.push_back(make_sweep(32'd300));
    pending_words.push_back(make_pkt(32'd310, 48'h0, ctt_pkg::PKT_DISCONNECT, 16'd0, 16'd0));
    pending_words.push_back(make_pkt(32'd320, 48'hFFFF_FFFF_FFFF, ctt_pkg::PKT_DISCONNECT,
                                     16'd0, 16'd0));
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_pkt(32'hFFFF_FFF0, 48'({$urandom, $urandom}),
                                       ctt_pkg::PKT_REQUEST, 16'($urandom), 16'd0));
    pending_words.push_back(make_sweep(32'd9000));
    drain_queue();

    cfg_write(ctt_pkg::CFG_PROTOCOL, 32'hFFFF_FFFF);
    cfg_write(ctt_pkg::CFG_TIMEOUT, 32'd0);
    pending_words.push_back(make_pkt(32'd5, 48'h5, ctt_pkg::PKT_REQUEST, 16'h5, 16'd0));
    begin
      pkt_word_t w;
      w = make_pkt(32'd6, 48'h6, ctt_pkg::PKT_REQUEST, 16'd0, 16'd0);
      w.protocol_id = 32'd0;
      pending_words.push_back(w);
    end
    pending_words.push_back(make_sweep(32'd5));
    pending_words.push_back(make_sweep(32'd6));
    drain_queue();

    random_phase(28, 32'd0, 3);
    drain_queue();
    cfg_write(ctt_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    cfg_write(ctt_pkg::CFG_PROTOCOL, $urandom);
    random_phase(28, 32'hFFFF_FF00, 2000);
    drain_queue();
    cfg_write(ctt_pkg::CFG_TIMEOUT, 32'd40);
    random_phase(28, $urandom, 20);
    drain_queue();

    $display("Sent %0d words (%0d result words checked) over four register settings,",
             sent, seen);
    $display("covering handshakes, full table, bad protocol, sweeps and timeouts.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    wait (cycles > 400000);
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/ctt_pkg.sv
src/ctt_datapath.sv
src/ctt_controller.sv
src/connection_tracking_table.sv
test/tb_connection_tracking_table.sv
